>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk; arst_n masks only CB_ASSERT.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define CB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

>>> rtl/core/cb32_pkg.sv
// ----------------------------------------------------------------------------
// cb32_pkg
// Types and constants of the Crockford Base32 80-bit code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cb32_pkg;

	localparam int SEED_W = 40;
	localparam int SYM_W  = 5;
	localparam int CNT_W  = 5;
	localparam int POS_W  = 4;
	localparam int CHAR_W = 8;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] HALF_SYMS = 5'd8;
	localparam logic [CNT_W-1:0] CODE_SYMS = 5'd16;
	localparam logic [CNT_W-1:0] COUNT_CAP = 5'd17;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_LEN  = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_CHAR = 2'd2;

	// decoded character
	typedef struct packed {
		logic             is_sep;
		logic             ok;
		logic [SYM_W-1:0] val;
	} sym_t;

	// one result word
	typedef struct packed {
		logic              valid_res;
		logic [STAT_W-1:0] status;
		logic [SEED_W-1:0] seed_high;
		logic [SEED_W-1:0] seed_low;
		logic [POS_W-1:0]  bad_position;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/core/cb32_sym_dec.sv
// ----------------------------------------------------------------------------
// cb32_sym_dec
// Character to 5-bit Crockford symbol, with separator and invalid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_sym_dec (
	input  wire logic [cb32_pkg::CHAR_W-1:0] char_code,
	output cb32_pkg::sym_t                   sym
);
	import cb32_pkg::*;

	logic [CHAR_W-1:0] up;

	always_comb begin
		// fold lower case only; codes 128..255 pass through unchanged
		if (char_code >= 8'h61 && char_code <= 8'h7A) begin
			up = char_code - 8'h20;
		end else begin
			up = char_code;
		end
	end

	always_comb begin
		sym.is_sep = (char_code == 8'h2D) || (char_code == 8'h20) || (char_code == 8'h2E);
		sym.ok     = 1'b1;
		sym.val    = '0;
		unique case (up) inside
			8'h49, 8'h4C:   sym.val = 5'd1;                 // I, L
			8'h4F:          sym.val = 5'd0;                 // O
			[8'h30:8'h39]:  sym.val = {1'b0, up[3:0]};      // 0-9
			[8'h41:8'h48]:  sym.val = up[4:0] + 5'd9;       // A-H
			[8'h4A:8'h4B]:  sym.val = up[4:0] + 5'd8;       // J-K
			[8'h4D:8'h4E]:  sym.val = up[4:0] + 5'd7;       // M-N
			[8'h50:8'h54]:  sym.val = up[4:0] + 5'd6;       // P-T
			[8'h56:8'h5A]:  sym.val = up[4:0] + 5'd5;       // V-Z
			default:        sym.ok  = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/cb32_accum.sv
// ----------------------------------------------------------------------------
// cb32_accum
// 80-bit symbol accumulator, status logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cb32_accum (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire logic           item_last,
	input  wire cb32_pkg::sym_t sym,
	input  wire logic           out_ready,
	output logic                advance,
	output logic                res_valid,
	output cb32_pkg::res_t      res
);
	import cb32_pkg::*;

	logic [SEED_W-1:0] hi_q, hi_n;
	logic [SEED_W-1:0] lo_q, lo_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              bad_q, bad_n;
	logic [POS_W-1:0]  fbi_q, fbi_n;
	logic [SYM_W-1:0]  v;
	logic              out_free;
	res_t              res_n;
	res_t              res_q;
	logic              res_valid_q;

	always_comb begin
		hi_n  = hi_q;
		lo_n  = lo_q;
		cnt_n = cnt_q;
		bad_n = bad_q;
		fbi_n = fbi_q;
		v     = sym.ok ? sym.val : '0;
		if (!sym.is_sep) begin
			// symbols past sixteen are only counted
			if (cnt_q < CODE_SYMS) begin
				if (!sym.ok && !bad_q) begin
					bad_n = 1'b1;
					fbi_n = cnt_q[POS_W-1:0];
				end
				if (cnt_q < HALF_SYMS) begin
					hi_n = {hi_q[SEED_W-SYM_W-1:0], v};
				end else begin
					lo_n = {lo_q[SEED_W-SYM_W-1:0], v};
				end
			end
			if (cnt_q < COUNT_CAP) begin
				cnt_n = cnt_q + 5'd1;
			end
		end
	end

	always_comb begin
		res_n = '0;
		if (cnt_n != CODE_SYMS) begin
			res_n.status = ST_BAD_LEN;     // length wins over bad chars
		end else if (bad_n) begin
			res_n.status       = ST_BAD_CHAR;
			res_n.bad_position = fbi_n;
		end else begin
			res_n.valid_res = 1'b1;
			res_n.status    = ST_OK;
			res_n.seed_high = hi_n;
			res_n.seed_low  = lo_n;
		end
	end

	assign out_free = !res_valid_q || out_ready;
	assign advance  = item_valid && (!item_last || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q  <= '0;
			lo_q  <= '0;
			cnt_q <= '0;
			bad_q <= 1'b0;
			fbi_q <= '0;
		end else if (advance) begin
			if (item_last) begin
				hi_q  <= '0;
				lo_q  <= '0;
				cnt_q <= '0;
				bad_q <= 1'b0;
				fbi_q <= '0;
			end else begin
				hi_q  <= hi_n;
				lo_q  <= lo_n;
				cnt_q <= cnt_n;
				bad_q <= bad_n;
				fbi_q <= fbi_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_last) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_last) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> rtl/core/crockford_base32_decoder_80bit.sv
// ----------------------------------------------------------------------------
// crockford_base32_decoder_80bit
// Decodes a 16-symbol Crockford Base32 string into an 80-bit seed.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): char_code plus last, one character word
// per cycle while in_ready is high. Dash, space and period are skipped;
// every other character is a symbol. The word marked last closes the string.
// Output channel (out_valid/out_ready): one result word per string, carrying
// valid_res, status (ok, wrong length, bad character), seed_high, seed_low
// and bad_position. Wrong length overrides bad character; seeds read zero
// unless the status is ok.
// Order: a word taken into the input register is decoded there and folded
// into the accumulator when it advances; a last word is folded into its
// result, which is loaded into the result register that drives the output.
// Throughput: one character per cycle while in_ready is high, set by the
// combinational lookup and 5-bit shift between input register and accumulator.
// Stall: the result register holds while out_ready is low. Non-last words
// keep flowing; a last word waits in the input register, and in_ready drops,
// only while a previous result is still unread.
// Reset: arst_n clears the accumulator, symbol count and both valids.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crockford_base32_decoder_80bit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// character words
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [cb32_pkg::CHAR_W-1:0]   char_code,
	input  wire logic                          last,
	// result words
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               valid_res,
	output logic [cb32_pkg::STAT_W-1:0]        status,
	output logic [cb32_pkg::SEED_W-1:0]        seed_high,
	output logic [cb32_pkg::SEED_W-1:0]        seed_low,
	output logic [cb32_pkg::POS_W-1:0]         bad_position
);
	import cb32_pkg::*;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	sym_t sym;
	logic advance;
	logic res_valid;
	res_t res;

	// stage 1 frees up whenever its word moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last;
		end
	end

	cb32_sym_dec u_dec (
		.char_code (char_s1),
		.sym       (sym)
	);

	cb32_accum u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_last  (last_s1),
		.sym        (sym),
		.out_ready  (out_ready),
		.advance    (advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign out_valid    = res_valid;
	assign valid_res    = res.valid_res;
	assign status       = res.status;
	assign seed_high    = res.seed_high;
	assign seed_low     = res.seed_low;
	assign bad_position = res.bad_position;

	// valid_res flags exactly the ok status
	`CB_ASSERT(a_ok_flag, out_valid |-> (valid_res == (status == ST_OK)), "valid_res/status mismatch")
	// a bad position only goes with a bad-character status
	`CB_ASSERT(a_pos_zero, (out_valid && status != ST_BAD_CHAR) |-> (bad_position == '0),
		"bad_position set without bad-character status")
	// input backs up only behind a last word facing a stalled result
	`CB_ASSERT(a_bp_cause, !in_ready |-> (valid_s1 && last_s1 && out_valid && !out_ready),
		"in_ready low without a stalled result")
	// seeds stay zero unless ok
	`CB_ASSERT(a_seed_zero, (out_valid && !valid_res) |-> (seed_high == '0 && seed_low == '0),
		"seed present on a failed decode")

endmodule

`default_nettype wire
